// ===== sv/sha1_pkg.sv =====
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;

	function automatic word_t init_chain(input logic [2:0] i);
		word_t r;
		case (i)
			3'd0: r = H0;
			3'd1: r = H1;
			3'd2: r = H2;
			3'd3: r = H3;
			default: r = H4;
		endcase
		return r;
	endfunction

	function automatic word_t round_f(input logic [6:0] t, input word_t b, input word_t c,
			input word_t d);
		word_t r;
		if (t < 7'd20) r = (b & c) | (~b & d);
		else if (t < 7'd40) r = b ^ c ^ d;
		else if (t < 7'd60) r = (b & c) | (b & d) | (c & d);
		else r = b ^ c ^ d;
		return r;
	endfunction

	function automatic word_t round_k(input logic [6:0] t);
		word_t r;
		if (t < 7'd20) r = K0;
		else if (t < 7'd40) r = K1;
		else if (t < 7'd60) r = K2;
		else r = K3;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/sha1_message_digest_top.sv =====
// Streaming SHA-1 hasher. Each input transfer carries at most one message byte
// (has_byte) and may mark the end of the message (end_of_message). Bytes are
// packed big-endian into a 16-word block memory. When 64 bytes are in, the
// 80-round compression runs. A plain byte is read and merged, then written
// back before the next transfer is taken. The round loop dominates. Each of
// the first 16 rounds reads its message word from the block memory, which
// has one read port and one write port, and then runs the round. Each later
// round reads the four message schedule taps, one per cycle, then computes
// the new schedule word and the round and writes the word back. The byte
// that fills a block holds off the next input transfer until the compression
// and the final add are done. An end-of-message transfer pads the block with
// 0x80, zeros and the 64-bit bit length. This takes one or two blocks, and
// the zero fill runs one word per cycle. The block then presents the five
// digest words, most significant first, one per output transfer. The output
// holds in a register while stall is high. The next message is accepted
// only after the last digest word has been transferred. The block memory
// needs no clearing after reset, since every word is fully written before a
// round reads it.
`default_nettype none
module sha1_message_digest_top
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BYTE  = 4'd1;  // not used; a byte is read in ST_IDLE and written in ST_BWR
	localparam logic [3:0] ST_BWR   = 4'd2;
	localparam logic [3:0] ST_PAD   = 4'd3;  // put the pad byte
	localparam logic [3:0] ST_PWR   = 4'd4;
	localparam logic [3:0] ST_ZERO  = 4'd5;  // zero fill words
	localparam logic [3:0] ST_LEN   = 4'd6;  // write length words
	localparam logic [3:0] ST_CINIT = 4'd7;
	localparam logic [3:0] ST_RD    = 4'd8;  // read schedule words
	localparam logic [3:0] ST_RND   = 4'd9;
	localparam logic [3:0] ST_ADD   = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]  state_q;
	word_t       mem [16];
	word_t       rdata_s1;
	logic [3:0]  raddr;
	logic        ren;
	logic [3:0]  waddr;
	word_t       wdata;
	logic        wen;

	word_t       h_q [5];
	word_t       a_q, b_q, c_q, d_q, e_q;
	word_t       x_q;
	logic [6:0]  round_counter_q;
	logic [1:0]  rd_q;     // which schedule tap is being read
	logic [63:0] bit_count_q;
	logic [7:0]  byte_q;
	logic        eom_q;
	logic        final_q;  // the block being compressed holds the length
	logic        two_q;    // padding needs a second block
	logic [3:0]  zidx_q;
	logic [2:0]  oidx_q;

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		if (ren) rdata_s1 <= mem[raddr];
	end

	logic [5:0] pos;
	assign pos = bit_count_q[8:3];
	logic [4:0] sh;
	assign sh = 5'd24 - {pos[1:0], 3'b000};

	// schedule tap addresses: t+13, t+8, t+2, t
	logic [3:0] tbase;
	assign tbase = round_counter_q[3:0];
	always_comb begin
		raddr = tbase;
		case (rd_q)
			2'd0: raddr = tbase + 4'd13;
			2'd1: raddr = tbase + 4'd8;
			2'd2: raddr = tbase + 4'd2;
			default: raddr = tbase;
		endcase
		if (state_q == ST_IDLE || state_q == ST_PAD) raddr = pos[5:2];
	end

	word_t merged;
	assign merged = (rdata_s1 & ~(32'hFF << sh)) | ({24'd0, byte_q} << sh);
	// The pad byte keeps the message bytes above it and clears the bytes below.
	word_t padded;
	assign padded = (rdata_s1 & ~(32'hFFFF_FFFF >> {pos[1:0], 3'b000}))
		| ({24'd0, PAD_BYTE} << sh);
	word_t wnew;
	assign wnew = {(x_q ^ rdata_s1)} ;
	word_t wrot;
	assign wrot = {wnew[30:0], wnew[31]};
	word_t wuse;
	assign wuse = (round_counter_q < 7'd16) ? rdata_s1 : wrot;
	word_t tmp;
	assign tmp = {a_q[26:0], a_q[31:27]} + round_f(round_counter_q, b_q, c_q, d_q)
		+ e_q + round_k(round_counter_q) + wuse;

	always_comb begin
		ren = 1'b0;
		wen = 1'b0;
		waddr = pos[5:2];
		wdata = merged;
		unique case (state_q)
			ST_IDLE: ren = in_valid && has_byte;
			ST_PAD:  ren = 1'b1;
			ST_BWR: wen = 1'b1;
			ST_PWR: begin
				wen = 1'b1;
				wdata = padded;
			end
			ST_ZERO: begin
				wen = 1'b1;
				waddr = zidx_q;
				wdata = '0;
			end
			ST_LEN: begin
				wen = 1'b1;
				waddr = zidx_q;
				wdata = zidx_q[0] ? bit_count_q[31:0] : bit_count_q[63:32];
			end
			ST_RD: ren = (round_counter_q >= 7'd16) || (rd_q == 2'd3);
			ST_RND: begin
				wen = round_counter_q >= 7'd16;
				waddr = tbase;
				wdata = wrot;
			end
			default: ;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = state_q == ST_OUT;
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last_word = oidx_q == 3'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			x_q <= '0;
			byte_q <= '0;
			bit_count_q <= '0;
			round_counter_q <= '0;
			rd_q <= '0;
			eom_q <= 1'b0;
			final_q <= 1'b0;
			two_q <= 1'b0;
			zidx_q <= '0;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					byte_q <= data_byte;
					eom_q <= end_of_message;
					final_q <= 1'b0;
					if (has_byte) state_q <= ST_BWR;
					else if (end_of_message) state_q <= ST_PAD;
				end
				ST_BWR: begin
					bit_count_q <= bit_count_q + 64'd8;
					if (pos == 6'd63) state_q <= ST_CINIT;
					else if (eom_q) state_q <= ST_PAD;
					else state_q <= ST_IDLE;
				end
				ST_PAD: begin
					state_q <= ST_PWR;
				end
				ST_PWR: begin
					two_q <= pos >= 6'd56;
					zidx_q <= pos[5:2] + 4'd1;
					if (pos[5:2] == 4'd15) state_q <= (pos >= 6'd56) ? ST_CINIT : ST_LEN;
					else state_q <= ST_ZERO;
					if (pos[5:2] == 4'd13) begin
						state_q <= ST_LEN;
						zidx_q <= 4'd14;
					end
				end
				ST_ZERO: begin
					zidx_q <= zidx_q + 4'd1;
					if (zidx_q == 4'd15 && two_q) state_q <= ST_CINIT;
					else if (zidx_q == 4'd13 && !two_q) state_q <= ST_LEN;
				end
				ST_LEN: begin
					zidx_q <= zidx_q + 4'd1;
					if (zidx_q == 4'd15) begin
						state_q <= ST_CINIT;
						final_q <= 1'b1;
					end
				end
				ST_CINIT: begin
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
					round_counter_q <= '0;
					rd_q <= 2'd3;
					state_q <= ST_RD;
				end
				ST_RD: begin
					// Read data arrives in the cycle after its address.
					if (rd_q == 2'd1) x_q <= rdata_s1;
					else if (rd_q != 2'd0) x_q <= x_q ^ rdata_s1;
					if (rd_q == 2'd3) state_q <= ST_RND;
					else if (rd_q != 2'd0 || round_counter_q >= 7'd16) rd_q <= rd_q + 2'd1;
				end
				ST_RND: begin
					a_q <= tmp; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
					if (round_counter_q == 7'd79) state_q <= ST_ADD;
					else begin
						round_counter_q <= round_counter_q + 7'd1;
						rd_q <= (round_counter_q >= 7'd15) ? 2'd0 : 2'd3;
						state_q <= ST_RD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
					if (final_q) begin
						state_q <= ST_OUT;
						oidx_q <= '0;
					end else if (eom_q && two_q) begin
						zidx_q <= '0;
						two_q <= 1'b0;
						state_q <= ST_ZERO;
					end else if (eom_q) state_q <= ST_PAD;
					else state_q <= ST_IDLE;
				end
				ST_OUT: if (!out_stall) begin
					if (oidx_q == 3'd4) begin
						h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
						bit_count_q <= '0;
						eom_q <= 1'b0;
						state_q <= ST_IDLE;
					end else oidx_q <= oidx_q + 3'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> oidx_q <= 3'd4) else $error("digest index out of range");
	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RND |-> round_counter_q <= 7'd79) else $error("round overrun");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word_index))
		else $error("digest word lost under stall");
endmodule
`default_nettype wire
